// ===== rtl/core/arm_pc_relative_relocator_defines.svh =====
// Assertion macros shared by the relocator checker.
`ifndef ARM_PC_RELATIVE_RELOCATOR_DEFINES_SVH
`define ARM_PC_RELATIVE_RELOCATOR_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ARPR_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ARPR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/arpr_pkg.sv =====
// Types, constants and codes shared by the relocator modules.
`default_nettype none

package arpr_pkg;

   localparam int MAX_WINDOW_WORDS_DEFAULT = 32;
   localparam int WIN_W       = 7;
   localparam int CSR_INDEX_W = 8;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_ORIGIN = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW = 8'd1;

   // Rewrite forms handed from the front end to the back end.
   localparam logic [2:0] KIND_PASS  = 3'd0;
   localparam logic [2:0] KIND_CALL  = 3'd1;
   localparam logic [2:0] KIND_JUMP  = 3'd2;
   localparam logic [2:0] KIND_ADDPC = 3'd3;
   localparam logic [2:0] KIND_LOAD  = 3'd4;

   localparam logic [31:0] W_ADD_LR_PC4  = 32'hE28FE004;
   localparam logic [31:0] W_LDR_PC_M4   = 32'hE51FF004;
   localparam logic [31:0] W_PUSH_RS     = 32'hE52D0004;
   localparam logic [31:0] W_LDR_RS_P8   = 32'hE59F0008;
   localparam logic [31:0] W_POP_RS      = 32'hE49D0004;
   localparam logic [31:0] W_ADD_PC_PC0  = 32'hE28FF000;
   localparam logic [31:0] W_LDR_RD_PC   = 32'hE51F0000;

   typedef struct packed {
      logic [31:0] instr_word;
      logic [31:0] literal_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] out_word;
      logic        last_word;
   } rsp_payload_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [31:0] word;
      logic [31:0] value;
      logic        tail;
      logic [31:0] ret_addr;
   } desc_type;

endpackage

`default_nettype wire

// ===== rtl/core/arpr_queue.sv =====
// Short descriptor queue between the classifier and the emitter.
`default_nettype none

module arpr_queue
   import arpr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire desc_type push_data,
   output logic          full,
   input  wire logic     pop,
   output logic          empty,
   output desc_type      head
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);

   desc_type         entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign head    = entries_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/arpr_front.sv =====
// Front end: configuration, window tracking and instruction classification.
`default_nettype none

module arpr_front
   import arpr_pkg::*;
#(
   parameter int MAX_WINDOW_WORDS = MAX_WINDOW_WORDS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   input  wire req_payload_type        req_payload,
   input  wire logic                   queue_full,
   output logic                        desc_push,
   output desc_type                    desc,
   input  wire logic                   csr_valid,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   localparam logic [WIN_W-1:0] MAX_WIN = WIN_W'(MAX_WINDOW_WORDS);

   logic [31:0] origin_ff, origin_in;
   logic [5:0]  window_ff, window_in;
   logic [5:0]  index_ff, index_in;
   logic [31:0] pc_ff, pc_in;

   logic [31:0] w, pc;
   logic        accept;
   logic        is_blx, is_bl, is_b, is_bx, is_branch;
   logic        is_addpc, is_adr_add, is_adr_sub, is_ldr, is_mov;
   logic [63:0] rot_pair;
   logic [31:0] rot_value;
   logic [31:0] branch_off;
   logic [31:0] add_opnd;
   logic        add_cin;
   logic [31:0] sum;
   logic [WIN_W-1:0] win;
   logic [5:0]  index_next;
   logic        tail;
   logic [31:0] ret_addr;

   assign w      = req_payload.instr_word;
   assign pc     = pc_ff;
   assign accept = req_push && !queue_full;

   // Priority decode; the condition field plays no part.
   assign is_blx     = (w[31:25] == 7'b1111101);
   assign is_bl      = !is_blx && (w[27:24] == 4'hB);
   assign is_b       = !is_blx && !is_bl && (w[27:24] == 4'hA);
   assign is_bx      = ((w & 32'h0FF000FF) == 32'h0120001F);
   assign is_branch  = is_blx || is_bl || is_b || is_bx;
   assign is_addpc   = ((w & 32'h0FEF0010) == 32'h008F0000);
   assign is_adr_add = ((w & 32'h0FFF0000) == 32'h028F0000);
   assign is_adr_sub = ((w & 32'h0FFF0000) == 32'h024F0000);
   assign is_ldr     = ((w & 32'h0E5F0000) == 32'h041F0000);
   assign is_mov     = ((w & 32'h0FE00FFF) == 32'h01A0000F);

   // ARM rotated immediate: imm8 rotated right by twice rot4.
   assign rot_pair  = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
   assign rot_value = rot_pair[31:0];

   // The BLX form carries H in bit 1 and marks the Thumb target in bit 0.
   assign branch_off = is_bx ? 32'd0
                     : {{6{w[23]}}, w[23:0], is_blx & w[24], is_blx};

   // One shared adder produces the branch targets and the PC-based values.
   always_comb begin
      add_opnd = 32'd0;
      add_cin  = 1'b0;
      if (is_branch) begin
         add_opnd = branch_off;
      end else if (is_addpc) begin
         add_opnd = 32'd0;
      end else if (is_adr_add) begin
         add_opnd = rot_value;
      end else if (is_adr_sub) begin
         add_opnd = ~rot_value;
         add_cin  = 1'b1;
      end
   end

   assign sum = pc + add_opnd + {31'd0, add_cin};

   always_comb begin
      if (window_ff == 6'd0) begin
         win = WIN_W'(1);
      end else if ({1'b0, window_ff} > MAX_WIN) begin
         win = MAX_WIN;
      end else begin
         win = {1'b0, window_ff};
      end
   end

   assign index_next = index_ff + 6'd1;
   assign tail       = ({1'b0, index_next} >= win);
   assign ret_addr   = origin_ff + {23'd0, win, 2'b00};

   always_comb begin
      desc.word     = w;
      desc.tail     = tail;
      desc.ret_addr = ret_addr;
      desc.value    = sum;
      if (is_blx || is_bl) begin
         desc.kind = KIND_CALL;
      end else if (is_b || is_bx) begin
         desc.kind = KIND_JUMP;
      end else if (is_addpc) begin
         desc.kind = KIND_ADDPC;
      end else if (is_adr_add || is_adr_sub || is_ldr || is_mov) begin
         desc.kind = KIND_LOAD;
         if (is_ldr && !is_adr_add && !is_adr_sub) begin
            desc.value = req_payload.literal_word;
         end
      end else begin
         desc.kind = KIND_PASS;
      end
   end

   assign desc_push = accept;

   // The running PC always holds the PC seen by the next item.
   always_comb begin
      origin_in = origin_ff;
      window_in = window_ff;
      index_in  = index_ff;
      pc_in     = pc_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ORIGIN: begin
               origin_in = csr_data;
               index_in  = 6'd0;
               pc_in     = csr_data + 32'd8;
            end
            CSR_WINDOW: begin
               window_in = csr_data[5:0];
               index_in  = 6'd0;
               pc_in     = origin_ff + 32'd8;
            end
            default: begin
            end
         endcase
      end else if (accept) begin
         if (tail) begin
            index_in = 6'd0;
            pc_in    = origin_ff + 32'd8;
         end else begin
            index_in = index_next;
            pc_in    = pc_ff + 32'd4;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_ff <= 32'd0;
         window_ff <= 6'd2;
         index_ff  <= 6'd0;
         pc_ff     <= 32'd8;
      end else begin
         origin_ff <= origin_in;
         window_ff <= window_in;
         index_ff  <= index_in;
         pc_ff     <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/arpr_back.sv =====
// Back end: expands one descriptor into its output words, one per cycle while the receiver pops.
`default_nettype none

module arpr_back
   import arpr_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     desc_valid,
   input  wire desc_type desc,
   output logic          desc_pop,
   output logic          rsp_empty,
   input  wire logic     rsp_pop,
   output rsp_payload_type rsp_payload
);

   logic [2:0]      step_ff, step_in;
   logic            out_valid_ff, out_valid_in;
   rsp_payload_type out_ff;

   logic [3:0]  body_len;
   logic [3:0]  total_len;
   logic        last;
   logic        load;
   logic [3:0]  rs;
   logic [31:0] rs_at_12;
   logic [31:0] word;

   always_comb begin
      case (desc.kind)
         KIND_CALL:  body_len = 4'd3;
         KIND_JUMP:  body_len = 4'd2;
         KIND_ADDPC: body_len = 4'd6;
         KIND_LOAD:  body_len = 4'd3;
         default:    body_len = 4'd1;
      endcase
   end

   assign total_len = body_len + (desc.tail ? 4'd2 : 4'd0);
   assign last      = ({1'b0, step_ff} == total_len - 4'd1);

   // Scratch register for the ADD form: the highest of r12, r11, r10 that
   // is neither Rd nor Rm.
   always_comb begin
      if (desc.word[15:12] != 4'd12 && desc.word[3:0] != 4'd12) begin
         rs = 4'd12;
      end else if (desc.word[15:12] != 4'd11 && desc.word[3:0] != 4'd11) begin
         rs = 4'd11;
      end else begin
         rs = 4'd10;
      end
   end

   assign rs_at_12 = {16'd0, rs, 12'd0};

   always_comb begin
      word = desc.word;
      if ({1'b0, step_ff} < body_len) begin
         case (desc.kind)
            KIND_CALL: begin
               case (step_ff)
                  3'd0:    word = W_ADD_LR_PC4;
                  3'd1:    word = W_LDR_PC_M4;
                  default: word = desc.value;
               endcase
            end
            KIND_JUMP: begin
               word = (step_ff == 3'd0) ? W_LDR_PC_M4 : desc.value;
            end
            KIND_ADDPC: begin
               case (step_ff)
                  3'd0:    word = W_PUSH_RS | rs_at_12;
                  3'd1:    word = W_LDR_RS_P8 | rs_at_12;
                  3'd2:    word = (desc.word & 32'hFFF0FFFF) | {12'd0, rs, 16'd0};
                  3'd3:    word = W_POP_RS | rs_at_12;
                  3'd4:    word = W_ADD_PC_PC0;
                  default: word = desc.value;
               endcase
            end
            KIND_LOAD: begin
               case (step_ff)
                  3'd0:    word = W_LDR_RD_PC | {16'd0, desc.word[15:12], 12'd0};
                  3'd1:    word = W_ADD_PC_PC0;
                  default: word = desc.value;
               endcase
            end
            default: word = desc.word;
         endcase
      end else if ({1'b0, step_ff} == body_len) begin
         word = W_LDR_PC_M4;
      end else begin
         word = desc.ret_addr;
      end
   end

   // The output register takes a new word whenever a descriptor is waiting and the register is free or drained.
   assign load     = desc_valid && (!out_valid_ff || rsp_pop);
   assign desc_pop = load && last;

   always_comb begin
      step_in      = step_ff;
      out_valid_in = out_valid_ff;
      if (load) begin
         step_in      = last ? 3'd0 : step_ff + 3'd1;
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= 3'd0;
         out_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_ff.out_word  <= word;
         out_ff.last_word <= last;
      end
   end

   assign rsp_empty   = !out_valid_ff;
   assign rsp_payload = out_ff;

endmodule

`default_nettype wire

// ===== rtl/core/arm_pc_relative_relocator.sv =====
// Top level of the ARM PC-relative instruction relocator.
// Usage: the host pushes one copied instruction word per item on the req_
// queue port (push when full is low), with the loaded word for a literal
// LDR. Relocated words come out on the rsp_ queue port, oldest first; pop
// takes the word shown while empty is low. last_word marks the final word
// that an item produces, including the return jump after the window.
// The csr_ port writes the origin address (index 0) or the window size
// (index 1); csr_ready is always high and a write to either register
// restarts the window.
// An item is written into the descriptor queue; its first word is then
// registered in the output register. The emitter sends one word per cycle
// while the receiver pops, and an item yields 1 to 8 words (1 for a plain
// word, up to 6 for ADD with PC, plus 2 for the last item of a window). A
// four-entry queue lets new items be taken while earlier ones still expand.
// Reset clears the window position, sets the origin to 0 and the window
// to two words, and empties both queues. When the receiver stops popping,
// the current word holds, the queue fills and full rises.
`default_nettype none

module arm_pc_relative_relocator
   import arpr_pkg::*;
#(
   parameter int MAX_WINDOW_WORDS = MAX_WINDOW_WORDS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_push,
   output logic                        req_full,
   input  wire req_payload_type        req_payload,
   output logic                        rsp_empty,
   input  wire logic                   rsp_pop,
   output rsp_payload_type             rsp_payload,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   desc_type front_desc;
   desc_type head_desc;
   logic     front_push;
   logic     queue_empty;
   logic     queue_pop;

   assign csr_ready = 1'b1;

   arpr_front #(
      .MAX_WINDOW_WORDS(MAX_WINDOW_WORDS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_payload(req_payload),
      .queue_full (req_full),
      .desc_push  (front_push),
      .desc       (front_desc),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   arpr_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (front_push),
      .push_data(front_desc),
      .full     (req_full),
      .pop      (queue_pop),
      .empty    (queue_empty),
      .head     (head_desc)
   );

   arpr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .desc_valid (!queue_empty),
      .desc       (head_desc),
      .desc_pop   (queue_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire

// ===== rtl/core/arpr_checker.sv =====
// Port-level checker for the relocator, bound to the top level.
`default_nettype none
`include "arm_pc_relative_relocator_defines.svh"

module arpr_checker
   import arpr_pkg::*;
(
   input wire logic            clock,
   input wire logic            reset,
   input wire logic            req_full,
   input wire logic            rsp_empty,
   input wire logic            rsp_pop,
   input wire rsp_payload_type rsp_payload
);

   `ARPR_ASSERT_NEXT(a_reset_clears, clock, 1'b0, reset, rsp_empty && !req_full, "queues not empty after reset")
   `ARPR_ASSERT_SAME(a_full_has_word, clock, reset, req_full, !rsp_empty, "input queue full while no word is offered")
   `ARPR_ASSERT_NEXT(a_item_continues, clock, reset, rsp_pop && !rsp_empty && !rsp_payload.last_word, !rsp_empty, "gap inside the words of one item")
   `ARPR_ASSERT_NEXT(a_stall_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_payload), "offered word changed during a stall")

endmodule

bind arm_pc_relative_relocator arpr_checker u_checker (.*);

`default_nettype wire

// ===== tb/arm_pc_relative_relocator_tb.sv =====
// Testbench for the ARM PC-relative relocator with its own predictor and a scoreboard.
`default_nettype none

module arm_pc_relative_relocator_tb;
   import arpr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_WINDOW   = MAX_WINDOW_WORDS_DEFAULT;
   localparam int CYCLE_LIMIT  = 300000;
   localparam int IDLE_PERCENT = 23;
   localparam int HOLD_AT      = 120;
   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOP    = 8'hFF;

   // Opcode masks and match values used to classify an instruction word.
   localparam logic [31:0] MASK_BLX  = 32'hFE000000, MATCH_BLX  = 32'hFA000000;
   localparam logic [31:0] MASK_BR   = 32'h0F000000;
   localparam logic [31:0] MATCH_BL  = 32'h0B000000, MATCH_B    = 32'h0A000000;
   localparam logic [31:0] MASK_BX   = 32'h0FF000FF, MATCH_BX   = 32'h0120001F;
   localparam logic [31:0] MASK_ADD  = 32'h0FEF0010, MATCH_ADD  = 32'h008F0000;
   localparam logic [31:0] MASK_ADR  = 32'h0FFF0000;
   localparam logic [31:0] MATCH_ADRA = 32'h028F0000, MATCH_ADRS = 32'h024F0000;
   localparam logic [31:0] MASK_LDR  = 32'h0E5F0000, MATCH_LDR  = 32'h041F0000;
   localparam logic [31:0] MASK_MOV  = 32'h0FE00FFF, MATCH_MOV  = 32'h01A0000F;

   typedef enum int {
      FORM_PASS, FORM_BLX, FORM_BL, FORM_B, FORM_BX, FORM_ADD,
      FORM_ADR_ADD, FORM_ADR_SUB, FORM_LDR_LIT, FORM_MOV_PC, FORM_COUNT
   } form_type;

   logic                   clock;
   logic                   reset       = 1'b1;
   logic                   req_push    = 1'b0;
   logic                   req_full;
   req_payload_type        req_payload = '0;
   logic                   rsp_empty;
   logic                   rsp_pop     = 1'b0;
   rsp_payload_type        rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [31:0]            csr_data    = '0;

   arm_pc_relative_relocator i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_payload (req_payload),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // Predictor state: a copy of the registers and the window position.
   logic [31:0] origin_reg;
   logic [5:0]  window_reg;
   logic [5:0]  window_pos;
   logic [31:0] window_pc;

   req_payload_type pending_items[$];
   rsp_payload_type expected_words[$];
   rsp_payload_type want;
   int              error_count  = 0;
   int              results_seen = 0;
   int              cycle_count  = 0;
   int              hold_left    = 0;
   bit              hold_done    = 1'b0;
   bit              steady       = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic [31:0] rotated_imm(input logic [31:0] w);
      logic [63:0] twice;
      twice = {24'd0, w[7:0], 24'd0, w[7:0]} >> {w[11:8], 1'b0};
      return twice[31:0];
   endfunction

   function automatic int effective_window();
      int n;
      n = window_reg;
      if (n < 1) n = 1;
      if (n > MAX_WINDOW) n = MAX_WINDOW;
      return n;
   endfunction

   function automatic void add_word(input logic [31:0] w);
      rsp_payload_type r;
      r.out_word  = w;
      r.last_word = 1'b0;
      expected_words.push_back(r);
   endfunction

   // Expands one accepted instruction word into the words the block must emit.
   function automatic void relocate_word(input req_payload_type item);
      logic [31:0] w, pc, x, value;
      logic [3:0]  rd, rm, rs;
      int          first, win;
      w     = item.instr_word;
      rd    = w[15:12];
      first = expected_words.size();
      if (window_pos == 6'd0) window_pc = origin_reg + 32'd8;
      pc = window_pc;

      if ((w & MASK_BLX) == MATCH_BLX || (w & MASK_BR) == MATCH_BL ||
          (w & MASK_BR) == MATCH_B || (w & MASK_BX) == MATCH_BX) begin
         if ((w & MASK_BLX) == MATCH_BLX) begin
            x = {{6{w[23]}}, w[23:0], w[24], 1'b0};
            add_word(W_ADD_LR_PC4);
            add_word(W_LDR_PC_M4);
            add_word(pc + x + 32'd1);
         end else if ((w & MASK_BR) == MATCH_BL) begin
            x = {{6{w[23]}}, w[23:0], 2'b00};
            add_word(W_ADD_LR_PC4);
            add_word(W_LDR_PC_M4);
            add_word(pc + x);
         end else if ((w & MASK_BR) == MATCH_B) begin
            x = {{6{w[23]}}, w[23:0], 2'b00};
            add_word(W_LDR_PC_M4);
            add_word(pc + x);
         end else begin
            add_word(W_LDR_PC_M4);
            add_word(pc);
         end
      end else if ((w & MASK_ADD) == MATCH_ADD) begin
         // The scratch register is the highest of r12..r10 not used by the ADD.
         rm = w[3:0];
         rs = 4'd12;
         while (rs == rd || rs == rm) rs = rs - 4'd1;
         add_word(W_PUSH_RS | {16'd0, rs, 12'd0});
         add_word(W_LDR_RS_P8 | {16'd0, rs, 12'd0});
         add_word({w[31:20], rs, w[15:0]});
         add_word(W_POP_RS | {16'd0, rs, 12'd0});
         add_word(W_ADD_PC_PC0);
         add_word(pc);
      end else if ((w & MASK_ADR) == MATCH_ADRA || (w & MASK_ADR) == MATCH_ADRS ||
                   (w & MASK_LDR) == MATCH_LDR || (w & MASK_MOV) == MATCH_MOV) begin
         if ((w & MASK_ADR) == MATCH_ADRA) value = pc + rotated_imm(w);
         else if ((w & MASK_ADR) == MATCH_ADRS) value = pc - rotated_imm(w);
         else if ((w & MASK_LDR) == MATCH_LDR) value = item.literal_word;
         else value = pc;
         add_word(W_LDR_RD_PC | {16'd0, rd, 12'd0});
         add_word(W_ADD_PC_PC0);
         add_word(value);
      end else begin
         add_word(w);
      end

      window_pc  = pc + 32'd4;
      window_pos = window_pos + 6'd1;
      win        = effective_window();
      if (window_pos >= win) begin
         add_word(W_LDR_PC_M4);
         add_word(origin_reg + 32'd4 * win);
         window_pos = 6'd0;
      end
      if (expected_words.size() > first)
         expected_words[expected_words.size() - 1].last_word = 1'b1;
   endfunction

   function automatic req_payload_type random_item();
      req_payload_type item;
      logic [31:0] w;
      logic [3:0]  cond, rd, rm;
      form_type    form;
      cond = 4'($urandom);
      rd   = 4'($urandom);
      rm   = 4'($urandom);
      if ($urandom_range(2) == 0) begin
         rd = 4'(10 + $urandom_range(2));
         rm = 4'(10 + $urandom_range(2));
      end
      form = form_type'($urandom_range(FORM_COUNT - 1));
      w    = $urandom;
      case (form)
         FORM_BLX:     w = {7'b1111101, w[24:0]};
         FORM_BL:      w = {cond, 4'hB, w[23:0]};
         FORM_B:       w = {cond, 4'hA, w[23:0]};
         FORM_BX:      w = {cond, 8'h12, w[19:8], 8'h1F};
         FORM_ADD:     w = {cond, 7'b0000100, w[20], 4'hF, rd, w[11:5], 1'b0, rm};
         FORM_ADR_ADD: w = {cond, 12'h28F, w[15:0]};
         FORM_ADR_SUB: w = {cond, 12'h24F, w[15:0]};
         FORM_LDR_LIT: w = {cond, 3'b010, w[24:23], 1'b0, w[21], 5'h1F, w[15:0]};
         FORM_MOV_PC:  w = {cond, 7'b0001101, w[20:16], rd, 12'h00F};
         default:      w = $urandom;
      endcase
      item.instr_word   = w;
      item.literal_word = $urandom;
      return item;
   endfunction

   task automatic queue_item(input logic [31:0] w, input logic [31:0] lit);
      req_payload_type item;
      item.instr_word   = w;
      item.literal_word = lit;
      pending_items.push_back(item);
   endtask

   task automatic queue_random_items(input int count);
      for (int i = 0; i < count; i++) pending_items.push_back(random_item());
   endtask

   task automatic wait_drained();
      @(negedge clock);
      while (pending_items.size() != 0 || expected_words.size() != 0) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_ORIGIN) begin
         origin_reg = data;
         window_pos = 6'd0;
      end else if (idx == CSR_WINDOW) begin
         window_reg = data[5:0];
         window_pos = 6'd0;
      end
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Sender: offers the oldest pending item unless it idles this cycle.
   always @(negedge clock) begin
      if (reset || pending_items.size() == 0 ||
          (!steady && $urandom_range(99) < IDLE_PERCENT)) begin
         req_push <= 1'b0;
      end else begin
         req_push    <= 1'b1;
         req_payload <= pending_items[0];
      end
   end

   always @(posedge clock) begin
      if (!reset && req_push && !req_full) begin
         relocate_word(req_payload);
         void'(pending_items.pop_front());
      end
   end

   // Receiver: random pops, plus one long hold-off so the block backs up.
   always @(negedge clock) begin
      if (!hold_done && results_seen >= HOLD_AT) begin
         hold_left = HOLD_CYCLES;
         hold_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_pop <= 1'b0;
      end else begin
         rsp_pop <= !reset && (steady || $urandom_range(99) >= IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_pop && !rsp_empty) begin
         results_seen = results_seen + 1;
         if (expected_words.size() == 0) begin
            error_count = error_count + 1;
            $display("%0t: unexpected word %h last %b", $realtime,
                     rsp_payload.out_word, rsp_payload.last_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_payload.out_word !== want.out_word) begin
               error_count = error_count + 1;
               $display("%0t: out_word expected %h actual %h", $realtime,
                        want.out_word, rsp_payload.out_word);
            end
            if (rsp_payload.last_word !== want.last_word) begin
               error_count = error_count + 1;
               $display("%0t: last_word expected %b actual %b", $realtime,
                        want.last_word, rsp_payload.last_word);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d words outstanding", $realtime,
                  expected_words.size());
         $display("arm_pc_relative_relocator_tb: done, errors");
         $finish;
      end
   end

   initial begin
      origin_reg = 32'd0;
      window_reg = 6'd2;
      window_pos = 6'd0;
      window_pc  = 32'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words under the reset configuration.
      queue_item(32'h00000000, 32'hFFFFFFFF);
      queue_item(32'hFFFFFFFF, 32'h00000000);
      queue_item(32'hFB7FFFFF, 32'h0);  // BLX with H set, largest forward offset
      queue_item(32'hFA800000, 32'h0);  // BLX, largest backward offset
      queue_item(32'hEB000000, 32'h0);
      queue_item(32'hEBFFFFFF, 32'h0);
      queue_item(32'h1A7FFFFF, 32'h0);  // conditional B; the rewrite ignores the condition
      queue_item(32'hEA800000, 32'h0);
      queue_item(32'hE12FFF1F, 32'h0);
      queue_item(32'h012FFF1F, 32'h0);
      queue_item(32'hE08F0001, 32'h0);
      queue_item(32'hE08FC00B, 32'h0);  // Rd and Rm take r12 and r11, scratch is r10
      queue_item(32'hE08FB00C, 32'h0);
      queue_item(32'hE08FC18C, 32'h0);
      queue_item(32'hE28F00FF, 32'h0);  // ADR with no rotation
      queue_item(32'hE28F1FFF, 32'h0);  // ADR with the largest rotation
      queue_item(32'hE24F2004, 32'h0);
      queue_item(32'hE24F3F01, 32'h0);
      queue_item(32'hE59F0010, 32'h00000000);
      queue_item(32'hE51FF008, 32'hFFFFFFFF);
      queue_item(32'hE1A0000F, 32'h0);
      queue_item(32'h01B0E00F, 32'h0);
      wait_drained();

      // Address sums wrap past the top of memory; one-word window.
      write_csr(CSR_ORIGIN, 32'hFFFFFFFC);
      write_csr(CSR_WINDOW, 32'd1);
      queue_random_items(50);
      wait_drained();

      steady = 1'b1;
      write_csr(CSR_ORIGIN, 32'h00000000);
      write_csr(CSR_WINDOW, MAX_WINDOW);
      queue_random_items(70);
      wait_drained();
      steady = 1'b0;

      // A zero window acts as one word.
      write_csr(CSR_ORIGIN, $urandom);
      write_csr(CSR_WINDOW, 32'd0);
      queue_random_items(30);
      wait_drained();

      // Oversized window saturates at the maximum.
      write_csr(CSR_WINDOW, 32'd63);
      queue_random_items(40);
      wait_drained();

      // Unused indexes change nothing; upper data bits of the window are dropped.
      write_csr(CSR_UNUSED, $urandom);
      write_csr(CSR_TOP, $urandom);
      write_csr(CSR_WINDOW, 32'hFFFFFFC5);
      queue_random_items(40);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         write_csr(CSR_ORIGIN, $urandom);
         write_csr(CSR_WINDOW, $urandom_range(8, 1));
         queue_random_items(40);
         wait_drained();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0) begin
         $display("arm_pc_relative_relocator_tb: done, clean");
      end else begin
         $display("arm_pc_relative_relocator_tb: done, errors");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== arm_pc_relative_relocator.f =====
+incdir+rtl/core
rtl/core/arpr_pkg.sv
rtl/core/arpr_queue.sv
rtl/core/arpr_front.sv
rtl/core/arpr_back.sv
rtl/core/arm_pc_relative_relocator.sv
rtl/core/arpr_checker.sv
tb/arm_pc_relative_relocator_tb.sv
